### design/hcb_pkg.sv
// hcb_pkg: shared types and constants of the hsv color box frame detector
// holds the box layout, the queue item, register and color codes
// no dependencies
package hcb_pkg;

  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned BOX_W = 48;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned COLOR_W = 2;

  // largest count value; the frame-size cap is the smaller of this and MAX_FRAME_PIXELS
  localparam int unsigned COUNT_WIDTH_MAX = 8388607;
  localparam int unsigned MAX_FRAME_PIXELS_DEF = 4194304;

  // reciprocal tables of the hue and saturation scaling
  localparam int unsigned SDIV_W = 20;
  localparam int unsigned HDIV_W = 17;
  localparam int unsigned SDIV_NUM = 2 * 255 * 4096;
  localparam int unsigned HDIV_NUM = 2 * 30 * 4096;
  localparam int unsigned HUE_WRAP = 180;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [BOX_W-1:0] BOX_RESET = 48'hFFFF_B400_0000;
  localparam logic [LEVEL_W-1:0] MIN_HITS_RESET = 8'd200;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RED_BOX   = 2'd0,
    REG_GREEN_BOX = 2'd1,
    REG_BLUE_BOX  = 2'd2,
    REG_MIN_HITS  = 2'd3
  } hcb_reg_t;

  typedef enum logic [COLOR_W-1:0] {
    COLOR_NONE  = 2'd0,
    COLOR_RED   = 2'd1,
    COLOR_GREEN = 2'd2,
    COLOR_BLUE  = 2'd3
  } hcb_color_t;

  // low byte first: low hue, sat, value, then high hue, sat, value
  typedef struct packed {
    logic [LEVEL_W-1:0] hi_val;
    logic [LEVEL_W-1:0] hi_sat;
    logic [LEVEL_W-1:0] hi_hue;
    logic [LEVEL_W-1:0] lo_val;
    logic [LEVEL_W-1:0] lo_sat;
    logic [LEVEL_W-1:0] lo_hue;
  } hcb_box_t;

  // one classified pixel: box hits in the order red, green, blue
  typedef struct packed {
    logic [2:0] hit;
    logic       frame_end;
  } hcb_item_t;

endpackage

### design/hcb_front.sv
// hcb_front: three-stage pixel classifier, bgr to hsv and box tests
// depends on hcb_pkg
module hcb_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [hcb_pkg::LEVEL_W-1:0]    in_blue_level,
  input  logic [hcb_pkg::LEVEL_W-1:0]    in_green_level,
  input  logic [hcb_pkg::LEVEL_W-1:0]    in_red_level,
  input  logic                           in_frame_end,
  input  hcb_pkg::hcb_box_t              red_box,
  input  hcb_pkg::hcb_box_t              green_box,
  input  hcb_pkg::hcb_box_t              blue_box,
  output logic                           item_valid,
  input  logic                           item_ready,
  output hcb_pkg::hcb_item_t             item
);

  localparam int unsigned LW = hcb_pkg::LEVEL_W;
  localparam int unsigned XW = LW + 4;
  localparam int unsigned HPW = XW + hcb_pkg::HDIV_W + 1;
  localparam int unsigned SPW = LW + hcb_pkg::SDIV_W;
  localparam int unsigned TAB_N = 1 << LW;

  // reciprocal tables, entry 0 is zero
  logic [hcb_pkg::SDIV_W-1:0] sdiv_tab [TAB_N];
  logic [hcb_pkg::HDIV_W-1:0] hdiv_tab [TAB_N];

  for (genvar i = 0; i < TAB_N; i++) begin : g_tab
    localparam int unsigned Den = (i == 0) ? 1 : 2 * i;
    localparam int unsigned SdVal = (i == 0) ? 0 : (hcb_pkg::SDIV_NUM + i) / Den;
    localparam int unsigned HdVal = (i == 0) ? 0 : (hcb_pkg::HDIV_NUM + i) / Den;
    assign sdiv_tab[i] = hcb_pkg::SDIV_W'(SdVal);
    assign hdiv_tab[i] = hcb_pkg::HDIV_W'(HdVal);
  end

  function automatic logic in_box(hcb_pkg::hcb_box_t bx, logic [LW-1:0] h,
                                  logic [LW-1:0] s, logic [LW-1:0] v);
    in_box = (h >= bx.lo_hue) && (h <= bx.hi_hue) &&
             (s >= bx.lo_sat) && (s <= bx.hi_sat) &&
             (v >= bx.lo_val) && (v <= bx.hi_val);
  endfunction

  // stage 1: max, min, raw hue, reciprocal lookups
  logic                       s1_valid_r;
  logic                       s1_fe_r;
  logic [LW-1:0]              s1_mx_r;
  logic [LW-1:0]              s1_d_r;
  logic signed [XW-1:0]       s1_x_r;
  logic [hcb_pkg::SDIV_W-1:0] s1_sd_r;
  logic [hcb_pkg::HDIV_W-1:0] s1_hd_r;
  // stage 2: products
  logic                       s2_valid_r;
  logic                       s2_fe_r;
  logic [LW-1:0]              s2_mx_r;
  logic [SPW-1:0]             s2_sprod_r;
  logic signed [HPW-1:0]      s2_hprod_r;
  // stage 3: box hits
  logic                       s3_valid_r;
  hcb_pkg::hcb_item_t         s3_item_r;

  logic s1_ready, s2_ready, s3_ready;
  logic s1_load, s2_load, s3_load;

  assign s3_ready = !s3_valid_r || item_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign s1_load = in_valid && s1_ready;
  assign s2_load = s1_valid_r && s2_ready;
  assign s3_load = s2_valid_r && s3_ready;
  assign in_stall = !s1_ready;

  logic [LW-1:0]        mx, mn, dd;
  logic signed [XW-1:0] bs, gs, rs, ds, xx;

  always_comb begin
    mx = in_blue_level;
    mn = in_blue_level;
    if (in_green_level > mx) mx = in_green_level;
    if (in_red_level > mx) mx = in_red_level;
    if (in_green_level < mn) mn = in_green_level;
    if (in_red_level < mn) mn = in_red_level;
    dd = mx - mn;
    bs = $signed(XW'(in_blue_level));
    gs = $signed(XW'(in_green_level));
    rs = $signed(XW'(in_red_level));
    ds = $signed(XW'(dd));
    if (mx == in_red_level) begin
      xx = gs - bs;
    end else if (mx == in_green_level) begin
      xx = bs - rs + (ds <<< 1);
    end else begin
      xx = rs - gs + (ds <<< 2);
    end
  end

  // stage 3 arithmetic: rounding shifts and hue wrap
  logic [SPW:0]          s_round;
  logic signed [HPW:0]   h_round;
  logic signed [HPW-12:0] h_floor;
  logic [LW-1:0]         sat, hue;

  always_comb begin
    s_round = {1'b0, s2_sprod_r} + (SPW + 1)'(2048);
    sat = s_round[LW+11:12];
    h_round = (HPW + 1)'(s2_hprod_r) + (HPW + 1)'(2048);
    h_floor = h_round[HPW:12];
    hue = h_floor[LW-1:0];
    if (h_floor < 0) hue = h_floor[LW-1:0] + LW'(hcb_pkg::HUE_WRAP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_valid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
      if (s3_ready) s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_fe_r <= in_frame_end;
      s1_mx_r <= mx;
      s1_d_r  <= dd;
      s1_x_r  <= xx;
      s1_sd_r <= sdiv_tab[mx];
      s1_hd_r <= hdiv_tab[dd];
    end
    if (s2_load) begin
      s2_fe_r    <= s1_fe_r;
      s2_mx_r    <= s1_mx_r;
      s2_sprod_r <= s1_d_r * s1_sd_r;
      s2_hprod_r <= s1_x_r * $signed({1'b0, s1_hd_r});
    end
    if (s3_load) begin
      s3_item_r.frame_end <= s2_fe_r;
      s3_item_r.hit[0] <= in_box(red_box, hue, sat, s2_mx_r);
      s3_item_r.hit[1] <= in_box(green_box, hue, sat, s2_mx_r);
      s3_item_r.hit[2] <= in_box(blue_box, hue, sat, s2_mx_r);
    end
  end

  assign item_valid = s3_valid_r;
  assign item = s3_item_r;

endmodule

### design/hcb_queue.sv
// hcb_queue: small fifo of classified pixels between front and back
// depends on hcb_pkg
module hcb_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  hcb_pkg::hcb_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output hcb_pkg::hcb_item_t pop_item
);

  localparam int unsigned DEPTH = hcb_pkg::QUEUE_DEPTH;
  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  hcb_pkg::hcb_item_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic push, pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign pop_item = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

endmodule

### design/hcb_back.sv
// hcb_back: per-box saturating hit counters and frame-end decision
// depends on hcb_pkg
module hcb_back #(
  parameter int unsigned MAX_FRAME_PIXELS = hcb_pkg::MAX_FRAME_PIXELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  hcb_pkg::hcb_item_t            item,
  input  logic [hcb_pkg::LEVEL_W-1:0]   min_hits,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hcb_pkg::COLOR_W-1:0]   out_detected_color
);

  localparam int unsigned CountCap = (MAX_FRAME_PIXELS < hcb_pkg::COUNT_WIDTH_MAX) ?
                                     MAX_FRAME_PIXELS : hcb_pkg::COUNT_WIDTH_MAX;
  localparam int unsigned CountW = $clog2(CountCap + 1);

  logic [CountW-1:0] cnt_r [3];
  logic [CountW-1:0] cnt_upd [3];
  logic              out_valid_r, out_valid_nxt;
  hcb_pkg::hcb_color_t color_r, color_nxt;
  logic out_free, take;

  assign out_free = !out_valid_r || !out_stall;
  // a frame-end transfer needs the output register free
  assign item_ready = !item.frame_end || out_free;
  assign take = item_valid && item_ready;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cnt_upd[k] = cnt_r[k];
      if (item.hit[k] && (cnt_r[k] < CountW'(CountCap))) cnt_upd[k] = cnt_r[k] + 1'b1;
    end
    if (cnt_upd[0] >= CountW'(min_hits)) begin
      color_nxt = hcb_pkg::COLOR_RED;
    end else if (cnt_upd[1] >= CountW'(min_hits)) begin
      color_nxt = hcb_pkg::COLOR_GREEN;
    end else if (cnt_upd[2] >= CountW'(min_hits)) begin
      color_nxt = hcb_pkg::COLOR_BLUE;
    end else begin
      color_nxt = hcb_pkg::COLOR_NONE;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (take && item.frame_end) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int k = 0; k < 3; k++) cnt_r[k] <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        for (int k = 0; k < 3; k++) cnt_r[k] <= item.frame_end ? '0 : cnt_upd[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.frame_end) color_r <= color_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_detected_color = color_r;

endmodule

### design/hsv_color_box_frame_detector_core.sv
// hsv_color_box_frame_detector_core: top level, config registers and the
// front classifier, queue and counter back end; depends on hcb_pkg and hcb_* modules
//
//   port group   direction  handshake            payload
//   in_*         input      in_valid / in_stall  blue, green, red level, frame_end
//   out_*        output     out_valid/out_stall  detected_color, frame end only
//   cfg_*        input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one pixel per cycle sustained unless out_stall backs up the path; out_valid rises
// once a frame-end pixel clears three classifier stages, the queue and counter stage
// synchronous active-low reset clears valids and counters, loads config reset values
// out_stall backs up the frame-end path first, then the queue, then in_stall
// cfg_ready always 1; the user writes config only while the block is idle, unchecked
module hsv_color_box_frame_detector_core #(
  parameter int unsigned MAX_FRAME_PIXELS = hcb_pkg::MAX_FRAME_PIXELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [hcb_pkg::LEVEL_W-1:0]       in_blue_level,
  input  logic [hcb_pkg::LEVEL_W-1:0]       in_green_level,
  input  logic [hcb_pkg::LEVEL_W-1:0]       in_red_level,
  input  logic                              in_frame_end,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [hcb_pkg::COLOR_W-1:0]       out_detected_color,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hcb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [hcb_pkg::BOX_W-1:0]         cfg_data
);

  hcb_pkg::hcb_box_t red_box_r, green_box_r, blue_box_r;
  logic [hcb_pkg::LEVEL_W-1:0] min_hits_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_box_r   <= hcb_pkg::BOX_RESET;
      green_box_r <= hcb_pkg::BOX_RESET;
      blue_box_r  <= hcb_pkg::BOX_RESET;
      min_hits_r  <= hcb_pkg::MIN_HITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hcb_pkg::REG_RED_BOX:   red_box_r <= cfg_data;
        hcb_pkg::REG_GREEN_BOX: green_box_r <= cfg_data;
        hcb_pkg::REG_BLUE_BOX:  blue_box_r <= cfg_data;
        hcb_pkg::REG_MIN_HITS:  min_hits_r <= cfg_data[hcb_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  logic               f_valid, f_ready;
  hcb_pkg::hcb_item_t f_item;
  logic               q_valid, q_ready;
  hcb_pkg::hcb_item_t q_item;

  hcb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_blue_level  (in_blue_level),
    .in_green_level (in_green_level),
    .in_red_level   (in_red_level),
    .in_frame_end   (in_frame_end),
    .red_box        (red_box_r),
    .green_box      (green_box_r),
    .blue_box       (blue_box_r),
    .item_valid     (f_valid),
    .item_ready     (f_ready),
    .item           (f_item)
  );

  hcb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  hcb_back #(
    .MAX_FRAME_PIXELS (MAX_FRAME_PIXELS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (q_valid),
    .item_ready         (q_ready),
    .item               (q_item),
    .min_hits           (min_hits_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_detected_color (out_detected_color)
  );

endmodule
